>>> hdl/lbs_pkg.sv
// Shared types, constants and helper functions of the skinning engine.
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

	// Signed Q16.16 word and groupings of words.
	typedef logic signed [31:0] word_t;
	typedef logic [3:0][31:0] row_t;
	typedef logic [2:0][31:0] vec3_t;

	// Elements of one 3x4 joint matrix and the marker of an unused bone.
	localparam int ELEMS_PER_JOINT = 12;
	localparam logic [7:0] UNUSED_BONE = 8'hFF;

	// Item codes of the operation field.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SKIN = 1'b1;

	// Depth of the result queue and the matching credit limit.
	localparam int QDEPTH = 4;
	localparam logic [2:0] QDEPTH_CNT = 3'd4;

	// Reciprocal of twelve in Q0.15, exact for slots below 1024.
	localparam logic [11:0] RECIP_12 = 12'd2731;

	// Control that travels with one bone through the lane pipeline.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		logic active;
	} ctl_t;

	// One skinned position.
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} res_t;

	// Saturates a wide signed value to 32 bits.
	function automatic word_t sat32(input logic signed [49:0] v);
		word_t r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/lbs_in_if.sv
// Input channel: write and skin items with valid and ready.
`timescale 1ns / 1ps
`default_nettype none
interface lbs_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [9:0]  palette_slot;
	logic signed [31:0] entry_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [31:0] bone_indices;
	logic [16:0] weight_0;
	logic [16:0] weight_1;
	logic [16:0] weight_2;
	logic [16:0] weight_3;

	modport source (
		output valid, operation, palette_slot, entry_value, pos_x, pos_y, pos_z,
		output bone_indices, weight_0, weight_1, weight_2, weight_3,
		input ready
	);
	modport sink (
		input valid, operation, palette_slot, entry_value, pos_x, pos_y, pos_z,
		input bone_indices, weight_0, weight_1, weight_2, weight_3,
		output ready
	);
endinterface
`default_nettype wire

>>> hdl/lbs_out_if.sv
// Output channel: skinned positions with valid and ready.
`timescale 1ns / 1ps
`default_nettype none
interface lbs_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

>>> hdl/lbs_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> hdl/lbs_row_lane.sv
// One row lane: transforms, weights and accumulates one output coordinate.
`timescale 1ns / 1ps
`default_nettype none
module lbs_row_lane (
	input  logic          clk,
	input  logic          arst_n,
	input  lbs_pkg::ctl_t ctl_s1,
	input  lbs_pkg::row_t m_s1,
	input  lbs_pkg::vec3_t pos_s1,
	input  logic [16:0]   w_s1,
	output logic          done_s5,
	output lbs_pkg::word_t row_s5
);
	import lbs_pkg::*;

	ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic signed [63:0] prod_s2 [3];
	word_t trans_s2;
	logic [16:0] w_s2, w_s3;
	word_t t_s3;
	logic signed [49:0] sum3;
	logic signed [49:0] wp_s4;
	logic signed [33:0] contrib;
	logic signed [35:0] acc_q;
	logic signed [35:0] next_acc;

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done_s5 <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done_s5 <= ctl_s4.vld && ctl_s4.last;
		end
	end

	// Stage 2: the three matrix by position products.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_s2[c] <= $signed(m_s1[c]) * $signed(pos_s1[c]);
		end
		trans_s2 <= $signed(m_s1[3]);
		w_s2 <= w_s1;
	end

	// Stage 3: floored products plus translation, saturated.
	assign sum3 = $signed(prod_s2[0][63:16]) + $signed(prod_s2[1][63:16])
		+ $signed(prod_s2[2][63:16]) + trans_s2;

	always_ff @(posedge clk) begin
		t_s3 <= sat32(sum3);
		w_s3 <= w_s2;
	end

	// Stage 4: weighting; an unused bone contributes nothing.
	always_ff @(posedge clk) begin
		if (ctl_s3.active) begin
			wp_s4 <= t_s3 * $signed({1'b0, w_s3});
		end else begin
			wp_s4 <= '0;
		end
	end

	// Stage 5: accumulation over the bones of one vertex.
	assign contrib = $signed(wp_s4[49:16]);
	assign next_acc = (ctl_s4.first ? 36'sd0 : acc_q) + contrib;

	always_ff @(posedge clk) begin
		if (ctl_s4.vld) begin
			acc_q <= next_acc;
		end
		row_s5 <= sat32({{14{next_acc[35]}}, next_acc});
	end
endmodule
`default_nettype wire

>>> hdl/lbs_out_queue.sv
// Result queue that holds the merged x, y, z results for the output channel.
`timescale 1ns / 1ps
`default_nettype none
module lbs_out_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lbs_pkg::res_t din,
	lbs_out_if.source     out_ch
);
	import lbs_pkg::*;

	res_t mem_q [QDEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = out_ch.valid && out_ch.ready;
	assign out_ch.valid = (cnt_q != 3'd0);
	assign out_ch.out_x = mem_q[rd_ptr_q].x;
	assign out_ch.out_y = mem_q[rd_ptr_q].y;
	assign out_ch.out_z = mem_q[rd_ptr_q].z;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b00, push} - {2'b00, pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end
endmodule
`default_nettype wire

>>> hdl/linear_blend_skinning.sv
// Top level of the four-bone linear blend skinning engine.
// Usage: items enter on in_ch. A write item (operation 0) stores one
// palette element at joint*12 + element; slots past the palette are
// dropped. A skin item (operation 1) reads one joint matrix per bone
// slot, one slot per cycle, and the front end takes no new item until
// the last slot of the vertex is issued. This bound is set by the single
// read port of the palette, which returns one whole matrix per cycle.
// Three row lanes then work in parallel through a five-stage multiply
// and accumulate pipeline, and each result enters the output queue
// once all three lanes have finished the last bone of its vertex.
// Results wait in a four-entry queue; when the receiver stalls, the
// queue fills and in_ch drops ready once four results are outstanding.
// Reset clears all control state; the palette holds no defined value
// until written and is never cleared.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_skinning #(
	parameter int NUM_JOINTS = 64,
	parameter int BONES_PER_VERTEX = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	lbs_in_if.sink    in_ch,
	lbs_out_if.source out_ch
);
	import lbs_pkg::*;

	localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam logic [1:0] LAST_K = 2'(BONES_PER_VERTEX - 1);
	localparam logic [11:0] SLOT_LIMIT = 12'(NUM_JOINTS * ELEMS_PER_JOINT);
	localparam logic [8:0] JOINT_LIMIT = 9'(NUM_JOINTS);

	logic busy_q;
	logic [1:0] k_q;
	vec3_t pos_q;
	logic [31:0] bones_q;
	logic [16:0] w_q [4];
	logic [2:0] outst_q;

	logic last_issue, in_fire, skin_fire, wr_fire, out_fire;
	logic [21:0] quot_prod;
	logic [6:0] quot;
	logic [10:0] quot12;
	logic [3:0] elem;
	logic slot_ok;
	logic [7:0] bone;
	logic active;

	ctl_t ctl_s1;
	vec3_t pos_s1;
	logic [16:0] w_s1;
	logic [ELEMS_PER_JOINT-1:0][31:0] m_s1;
	logic [2:0] done_s5;
	word_t row_s5 [3];
	res_t res;

	// Handshake: one vertex in the front end at a time, bounded by credit.
	assign last_issue = busy_q && (k_q == LAST_K);
	assign in_ch.ready = (!busy_q || last_issue) && (outst_q < QDEPTH_CNT);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign skin_fire = in_fire && (in_ch.operation == OP_SKIN);
	assign wr_fire = in_fire && (in_ch.operation == OP_WRITE);
	assign out_fire = out_ch.valid && out_ch.ready;

	// Slot split into joint and element by a reciprocal multiply.
	assign quot_prod = in_ch.palette_slot * RECIP_12;
	assign quot = quot_prod[21:15];
	assign quot12 = quot * 4'd12;
	assign elem = 4'(in_ch.palette_slot - quot12[9:0]);
	assign slot_ok = ({2'b00, in_ch.palette_slot} < SLOT_LIMIT);

	// Sequencer state and captured vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			outst_q <= '0;
		end else begin
			if (skin_fire) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (last_issue) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				k_q <= k_q + 2'd1;
			end
			outst_q <= outst_q + {2'b00, skin_fire} - {2'b00, out_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (skin_fire) begin
			pos_q <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
			bones_q <= in_ch.bone_indices;
			w_q[0] <= in_ch.weight_0;
			w_q[1] <= in_ch.weight_1;
			w_q[2] <= in_ch.weight_2;
			w_q[3] <= in_ch.weight_3;
		end
	end

	// Bone selection for the current slot.
	assign bone = bones_q[{k_q, 3'b000} +: 8];
	assign active = (bone != UNUSED_BONE) && ({1'b0, bone} < JOINT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld <= busy_q;
			ctl_s1.first <= (k_q == 2'd0);
			ctl_s1.last <= last_issue;
			ctl_s1.active <= active;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_q;
		w_s1 <= w_q[k_q];
	end

	// Palette: one RAM per matrix element, all read at the same joint.
	for (genvar e = 0; e < ELEMS_PER_JOINT; e++) begin : g_elem
		lbs_ram #(.WIDTH(32), .DEPTH(NUM_JOINTS)) u_ram (
			.clk     (clk),
			.wr_en   (wr_fire && slot_ok && (elem == 4'(e))),
			.wr_addr (AW'(quot)),
			.wr_data (in_ch.entry_value),
			.rd_addr (AW'(bone)),
			.rd_data (m_s1[e])
		);
	end

	// Row lanes.
	for (genvar r = 0; r < 3; r++) begin : g_lane
		lbs_row_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_s1  (ctl_s1),
			.m_s1    ({m_s1[r*4+3], m_s1[r*4+2], m_s1[r*4+1], m_s1[r*4]}),
			.pos_s1  (pos_s1),
			.w_s1    (w_s1),
			.done_s5 (done_s5[r]),
			.row_s5  (row_s5[r])
		);
	end

	// Merge of the lane results into the output queue.
	assign res.x = row_s5[0];
	assign res.y = row_s5[1];
	assign res.z = row_s5[2];

	lbs_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (done_s5[0] && done_s5[1] && done_s5[2]),
		.din    (res),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire

>>> tb/sv/lbs_skin_checker.sv
// Checker that watches both channels, predicts skinned positions and compares them.
`timescale 1ns / 1ps
`default_nettype none
module lbs_skin_checker #(
	parameter int NUM_JOINTS = 64,
	parameter int BONES_PER_VERTEX = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	lbs_in_if     in_ch,
	lbs_out_if    out_ch,
	output int    fail_count,
	output int    pending_count
);
	import lbs_pkg::*;

	// Shadow copy of the joint palette.
	logic signed [31:0] joint_palette [NUM_JOINTS*ELEMS_PER_JOINT];
	res_t skinned_queue [$];
	int mismatch_count;

	// Clamps to the signed 32-bit range; floor division by 2^16 below is an arithmetic shift right.
	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Weighted sum of the bone transforms of one vertex.
	function automatic res_t blend_vertex(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz,
			input logic [31:0] bones, input logic [16:0] w [4]);
		logic signed [63:0] acc [3];
		logic signed [63:0] pos [3];
		logic signed [63:0] t;
		logic signed [63:0] m;
		logic [7:0] bone;
		res_t r;
		pos[0] = px;
		pos[1] = py;
		pos[2] = pz;
		for (int i = 0; i < 3; i++) acc[i] = 0;
		for (int k = 0; k < BONES_PER_VERTEX && k < 4; k++) begin
			bone = bones[8*k +: 8];
			if (bone == UNUSED_BONE || bone >= NUM_JOINTS) continue;
			for (int rr = 0; rr < 3; rr++) begin
				t = joint_palette[bone*ELEMS_PER_JOINT + rr*4 + 3];
				for (int c = 0; c < 3; c++) begin
					m = joint_palette[bone*ELEMS_PER_JOINT + rr*4 + c];
					t += (m * pos[c]) >>> 16;
				end
				t = clamp32(t);
				acc[rr] += (t * $signed({47'd0, w[k]})) >>> 16;
			end
		end
		r.x = 32'(clamp32(acc[0]));
		r.y = 32'(clamp32(acc[1]));
		r.z = 32'(clamp32(acc[2]));
		return r;
	endfunction

	assign fail_count = mismatch_count;

	// Track writes, predict on each accepted skin item, compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		logic [16:0] w [4];
		if (!arst_n) begin
			mismatch_count <= 0;
			pending_count <= 0;
			skinned_queue.delete();
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.operation == OP_WRITE) begin
					if (in_ch.palette_slot < NUM_JOINTS*ELEMS_PER_JOINT)
						joint_palette[in_ch.palette_slot] = in_ch.entry_value;
				end else begin
					w[0] = in_ch.weight_0;
					w[1] = in_ch.weight_1;
					w[2] = in_ch.weight_2;
					w[3] = in_ch.weight_3;
					skinned_queue.insert(skinned_queue.size(), blend_vertex(in_ch.pos_x,
						in_ch.pos_y, in_ch.pos_z, in_ch.bone_indices, w));
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				got.x = out_ch.out_x;
				got.y = out_ch.out_y;
				got.z = out_ch.out_z;
				if (skinned_queue.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result %h %h %h", got.x, got.y, got.z);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = skinned_queue.pop_front();
					if (want != got) begin
						if (mismatch_count < 10)
							$display("mismatch: expected %h %h %h, got %h %h %h",
								want.x, want.y, want.z, got.x, got.y, got.z);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			pending_count <= skinned_queue.size();
		end
	end
endmodule
`default_nettype wire

>>> tb/sv/tb_linear_blend_skinning.sv
// Top of the skinning engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_linear_blend_skinning;
	import lbs_pkg::*;

	localparam int JOINTS = 64;
	localparam int SLOTS = JOINTS * ELEMS_PER_JOINT;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit joint_written [JOINTS];

	lbs_in_if in_ch ();
	lbs_out_if out_ch ();

	linear_blend_skinning u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	lbs_skin_checker #(.NUM_JOINTS(JOINTS), .BONES_PER_VERTEX(4)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit.
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver ready with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Random Q16.16 value, biased toward extremes and moderate magnitudes.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(131072*4)) - 262144;
		endcase
	endfunction

	function automatic logic [16:0] rand_weight();
		case ($urandom_range(4))
			0: return 17'd65536;
			1: return 17'h1FFFF;
			2: return 17'd0;
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	// Sends one item, with random sender gaps before it.
	task automatic send_item(input logic op, input logic [9:0] slot,
			input logic [31:0] value, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] bones, input logic [16:0] w0,
			input logic [16:0] w1, input logic [16:0] w2, input logic [16:0] w3);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.palette_slot <= slot;
		in_ch.entry_value <= value;
		in_ch.pos_x <= px;
		in_ch.pos_y <= py;
		in_ch.pos_z <= pz;
		in_ch.bone_indices <= bones;
		in_ch.weight_0 <= w0;
		in_ch.weight_1 <= w1;
		in_ch.weight_2 <= w2;
		in_ch.weight_3 <= w3;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Writes one element; a joint counts as written only once all of it is.
	task automatic write_entry(input logic [9:0] slot, input logic [31:0] value);
		send_item(OP_WRITE, slot, value, $urandom, $urandom, $urandom, $urandom,
			17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
	endtask

	// Writes a whole joint matrix; identity-like or random content.
	task automatic write_joint(input int j, input bit random_fill);
		for (int e = 0; e < ELEMS_PER_JOINT; e++) begin
			if (random_fill) write_entry(10'(j*ELEMS_PER_JOINT + e), rand_word());
			else write_entry(10'(j*ELEMS_PER_JOINT + e),
				(e % 5 == 0) ? 32'h0001_0000 : 32'd0);
		end
		joint_written[j] = 1'b1;
	endtask

	// Bone byte: a written joint, unused, or out of range.
	function automatic logic [7:0] rand_bone();
		int j;
		case ($urandom_range(9))
			0: return UNUSED_BONE;
			1: return 8'($urandom_range(254, JOINTS));
			default: begin
				j = $urandom_range(JOINTS-1);
				while (!joint_written[j]) j = $urandom_range(JOINTS-1);
				return 8'(j);
			end
		endcase
	endfunction

	task automatic skin_vertex(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] bones, input logic [16:0] w0,
			input logic [16:0] w1, input logic [16:0] w2, input logic [16:0] w3);
		send_item(OP_SKIN, 10'($urandom), $urandom, px, py, pz, bones, w0, w1, w2, w3);
	endtask

	task automatic skin_random();
		skin_vertex(rand_word(), rand_word(), rand_word(),
			{rand_bone(), rand_bone(), rand_bone(), rand_bone()},
			rand_weight(), rand_weight(), rand_weight(), rand_weight());
	endtask

	// Stimulus.
	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 68;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_WRITE;
		in_ch.palette_slot = '0;
		in_ch.entry_value = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.bone_indices = '0;
		in_ch.weight_0 = '0;
		in_ch.weight_1 = '0;
		in_ch.weight_2 = '0;
		in_ch.weight_3 = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity joint 0, extreme joint 63, dropped slots.
		write_joint(0, 1'b0);
		for (int e = 0; e < ELEMS_PER_JOINT; e++)
			write_entry(10'(63*ELEMS_PER_JOINT + e), e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
		joint_written[63] = 1'b1;
		write_entry(10'd768, 32'h1234_5678);
		write_entry(10'd1023, 32'hFFFF_FFFF);
		skin_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FF00,
			17'd65536, 17'd0, 17'd0, 17'd0);
		skin_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h3F3F_3F3F,
			17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		skin_vertex(32'h1234_5678, 32'h0, 32'h0, 32'hFFFF_FFFF,
			17'd65536, 17'd65536, 17'd65536, 17'd65536);
		skin_vertex(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFF80_40FF,
			17'd32768, 17'd65536, 17'd65536, 17'd1);
		skin_vertex(32'hFFFF_FFFF, 32'h1, 32'h8000_0001, 32'h00_3F_00_3F,
			17'd32768, 17'd32768, 17'd1, 17'h1FFFF);

		// Random: fill more joints, then mostly skin items with some rewrites.
		for (int j = 1; j < JOINTS - 1; j += 3) write_joint(j, 1'b1);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 68 : 0;
			recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 15 : 0;
			for (int n = 0; n < 120; n++) begin
				if ($urandom_range(9) == 0)
					write_entry(10'($urandom_range(1023)), rand_word());
				else skin_random();
			end
		end
		in_ch.valid <= 1'b0;

		// Drain.
		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
